// ===== rtl/quadrature_edge_period_speed_meter_assert.svh =====
// Assertion macros for the quadrature edge-period speed meter.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef QUADRATURE_EDGE_PERIOD_SPEED_METER_ASSERT_SVH
`define QUADRATURE_EDGE_PERIOD_SPEED_METER_ASSERT_SVH

// Condition that holds at every clock edge out of reset
`define QESM_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define QESM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qesm_pkg.sv =====
// Shared types and constants of the quadrature edge-period speed meter.
// No dependencies.
package qesm_pkg;

    localparam int RATE_W      = 32;
    localparam int THR_W       = 16;
    localparam int Q8_W        = 32;
    localparam int SCALE_SHIFT = 10;               // times 4 for the four-period sum, times 256 for Q8
    localparam int NUM_W       = RATE_W + SCALE_SHIFT;
    localparam int CFG_IDX_W   = 2;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESH = CFG_IDX_W'(1);

    typedef struct packed {
        logic [RATE_W-1:0] rate_scale;
        logic [THR_W-1:0]  low_speed_threshold;
    } qesm_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qesm_q_stat_t;

endpackage

// ===== rtl/qesm_tick_if.sv =====
// Tick channel: sampled encoder levels and read request per beat.
// No dependencies.
interface qesm_tick_if;
    logic valid;
    logic ready;
    logic level_a;
    logic level_b;
    logic read_speed;

    modport source (output valid, output level_a, output level_b, output read_speed,
                    input ready);
    modport sink   (input valid, input level_a, input level_b, input read_speed,
                    output ready);
endinterface

// ===== rtl/qesm_speed_if.sv =====
// Speed result channel: one Q24.8 rpm value per beat.
// Depends on qesm_pkg.
interface qesm_speed_if;
    logic                    valid;
    logic                    ready;
    logic [qesm_pkg::Q8_W-1:0] speed_q8;

    modport source (output valid, output speed_q8, input ready);
    modport sink   (input valid, input speed_q8, output ready);
endinterface

// ===== rtl/qesm_cfg_if.sv =====
// Configuration write channel: register index and data per beat.
// Depends on qesm_pkg.
interface qesm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [qesm_pkg::CFG_IDX_W-1:0] index;
    logic [qesm_pkg::RATE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/qesm_front.sv =====
// Front end: edge detection, saturating tick counters, period registers.
// Pushes the period sum of every read beat into the queue. Depends on qesm_pkg.
module qesm_front #(
    parameter int COUNT_WIDTH = 32,
    parameter int SUM_W       = COUNT_WIDTH + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    qesm_tick_if.sink            tick,
    input  qesm_pkg::qesm_q_stat_t q_stat,
    output logic                 push,
    output logic [SUM_W-1:0]     push_sum
);
    import qesm_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic                   last_a_reg, last_b_reg;
    logic [COUNT_WIDTH-1:0] ticks_a_reg, ticks_a_next;
    logic [COUNT_WIDTH-1:0] ticks_b_reg, ticks_b_next;
    logic [COUNT_WIDTH-1:0] a_rise_reg, a_rise_next, a_fall_reg, a_fall_next;
    logic [COUNT_WIDTH-1:0] b_rise_reg, b_rise_next, b_fall_reg, b_fall_next;
    logic [COUNT_WIDTH-1:0] inc_a, inc_b;
    logic                   accept;

    assign tick.ready = !q_stat.full;
    assign accept     = tick.valid && tick.ready;

    // Saturating increments
    assign inc_a = (ticks_a_reg == CNT_MAX) ? CNT_MAX : ticks_a_reg + COUNT_WIDTH'(1);
    assign inc_b = (ticks_b_reg == CNT_MAX) ? CNT_MAX : ticks_b_reg + COUNT_WIDTH'(1);

    // Edge handling per channel
    always_comb
    begin
        ticks_a_next = inc_a;
        a_rise_next  = a_rise_reg;
        a_fall_next  = a_fall_reg;
        if (tick.level_a != last_a_reg)
        begin
            ticks_a_next = '0;
            if (tick.level_a)
                a_rise_next = inc_a;
            else
                a_fall_next = inc_a;
        end
        ticks_b_next = inc_b;
        b_rise_next  = b_rise_reg;
        b_fall_next  = b_fall_reg;
        if (tick.level_b != last_b_reg)
        begin
            ticks_b_next = '0;
            if (tick.level_b)
                b_rise_next = inc_b;
            else
                b_fall_next = inc_b;
        end
    end

    // Read uses the periods as updated by this beat
    assign push     = accept && tick.read_speed;
    assign push_sum = SUM_W'(a_rise_next) + SUM_W'(a_fall_next)
                    + SUM_W'(b_rise_next) + SUM_W'(b_fall_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg  <= 1'b0;
            last_b_reg  <= 1'b0;
            ticks_a_reg <= '0;
            ticks_b_reg <= '0;
            a_rise_reg  <= '0;
            a_fall_reg  <= '0;
            b_rise_reg  <= '0;
            b_fall_reg  <= '0;
        end
        else if (accept)
        begin
            last_a_reg  <= tick.level_a;
            last_b_reg  <= tick.level_b;
            ticks_a_reg <= ticks_a_next;
            ticks_b_reg <= ticks_b_next;
            a_rise_reg  <= a_rise_next;
            a_fall_reg  <= a_fall_next;
            b_rise_reg  <= b_rise_next;
            b_fall_reg  <= b_fall_next;
        end
    end

endmodule

// ===== rtl/qesm_queue.sv =====
// Short FIFO of period sums between front and back end.
// Depends on qesm_pkg for depth and status type.
module qesm_queue #(
    parameter int SUM_W = 34
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [SUM_W-1:0]       push_sum,
    input  logic                   pop,
    output logic [SUM_W-1:0]       head_sum,
    output qesm_pkg::qesm_q_stat_t q_stat
);
    import qesm_pkg::*;

    logic [SUM_W-1:0]  entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_sum     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/qesm_back.sv =====
// Back end: restoring divider, one quotient bit per cycle, saturation,
// threshold and output register. Depends on qesm_pkg and the assert header.
`include "quadrature_edge_period_speed_meter_assert.svh"

module qesm_back #(
    parameter int SUM_W = 34
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  qesm_pkg::qesm_cfg_t    cfg,
    input  qesm_pkg::qesm_q_stat_t q_stat,
    input  logic [SUM_W-1:0]       head_sum,
    output logic                   pop,
    qesm_speed_if.source           speed
);
    import qesm_pkg::*;

    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN, S_OUT} state_t;

    state_t              state_reg, state_next;
    logic [SUM_W-1:0]    divisor_reg, divisor_next;
    logic [SUM_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    num_reg, num_next;    // dividend in, quotient out
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [Q8_W-1:0]     speed_reg, speed_next;
    logic [SUM_W:0]      rem_shift;
    logic                fits;
    logic [Q8_W-1:0]     quot_sat;

    assign pop            = (state_reg == S_IDLE) && !q_stat.empty;
    assign speed.valid    = (state_reg == S_OUT);
    assign speed.speed_q8 = speed_reg;

    // One restoring step
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign fits      = (rem_shift >= {1'b0, divisor_reg});

    // Saturate the quotient to 32 bits
    assign quot_sat = (|num_reg[NUM_W-1:Q8_W]) ? '1 : num_reg[Q8_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        num_next     = num_reg;
        step_next    = step_reg;
        speed_next   = speed_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    divisor_next = head_sum;
                    rem_next     = '0;
                    num_next     = {cfg.rate_scale, SCALE_SHIFT'(0)};
                    step_next    = '0;
                    if (head_sum == '0)
                    begin
                        speed_next = '0;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (fits)
                    rem_next = rem_shift[SUM_W-1:0] - divisor_reg;
                else
                    rem_next = rem_shift[SUM_W-1:0];
                num_next  = {num_reg[NUM_W-2:0], fits};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_W - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (quot_sat < Q8_W'(cfg.low_speed_threshold))
                    speed_next = '0;
                else
                    speed_next = quot_sat;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (speed.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            divisor_reg <= '0;
            rem_reg     <= '0;
            num_reg     <= '0;
            speed_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            divisor_reg <= divisor_next;
            rem_reg     <= rem_next;
            num_reg     <= num_next;
            speed_reg   <= speed_next;
        end
    end

    // Divider invariant: partial remainder stays below the divisor
    `QESM_ASSERT(a_rem_bound, (state_reg != S_DIV) || (rem_reg < divisor_reg), "remainder overflow")
    // A nonzero result never falls below the threshold
    `QESM_ASSERT(a_thresh, (state_reg != S_OUT) || (speed_reg == '0) || (speed_reg >= Q8_W'(cfg.low_speed_threshold)), "result below threshold")
    // A pop starts a division or a zero result in the next cycle
    `QESM_ASSERT_NEXT(a_pop_start, pop, (state_reg == S_DIV) || (state_reg == S_OUT), "pop without start")
    // Divider leaves for finishing only after its last step
    `QESM_ASSERT_NEXT(a_fin_step, (state_reg == S_DIV) && (step_reg != STEP_W'(NUM_W - 1)), state_reg == S_DIV, "divider ended early")

endmodule

// ===== rtl/quadrature_edge_period_speed_meter.sv =====
// Top level of the quadrature edge-period speed meter: configuration
// registers, front end, period-sum queue and divider back end.
// Depends on qesm_pkg, the channel interfaces and the qesm_* modules.

// Tick beats are taken one per clock while the queue is not full; each
// updates both channels' edge counters and period registers at once. A
// beat with read_speed set queues the sum of the four periods (as updated
// by that beat) and the back end turns it into rpm with a restoring
// divider, one bit per cycle, over the 42-bit numerator rate_scale*1024,
// in one load step, 42 divide steps and one saturate/threshold step (a
// zero period sum gives 0 with no division); no new read starts until
// the last result is taken. Up to four reads may wait in the queue;
// ticks are refused only while it is full. The configuration port is
// always ready, writes to an unknown index are dropped, and registers
// should be changed only while no read is outstanding.
module quadrature_edge_period_speed_meter #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    qesm_tick_if.sink     tick,
    qesm_speed_if.source  speed,
    qesm_cfg_if.sink      cfg
);
    import qesm_pkg::*;

    localparam int SUM_W = COUNT_WIDTH + 2;

    qesm_cfg_t        cfg_reg;
    qesm_q_stat_t     q_stat;
    logic             push, pop;
    logic [SUM_W-1:0] push_sum, head_sum;

    assign cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_scale          <= RATE_W'(1000000);
            cfg_reg.low_speed_threshold <= THR_W'(640);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_RATE_SCALE: cfg_reg.rate_scale          <= cfg.data;
                REG_LOW_THRESH: cfg_reg.low_speed_threshold <= cfg.data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    qesm_front #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .SUM_W       (SUM_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .q_stat   (q_stat),
        .push     (push),
        .push_sum (push_sum)
    );

    qesm_queue #(
        .SUM_W (SUM_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_sum (push_sum),
        .pop      (pop),
        .head_sum (head_sum),
        .q_stat   (q_stat)
    );

    qesm_back #(
        .SUM_W (SUM_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .head_sum (head_sum),
        .pop      (pop),
        .speed    (speed)
    );

endmodule
